### hdl/btni_pkg.sv
package btni_pkg;

  localparam int unsigned NUM_CLASS = 4;
  localparam int unsigned DEPTH     = 256;
  localparam int unsigned ORDER     = 4;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NOT_LOADED = 3'd1;
  localparam logic [2:0] ST_ABSENT     = 3'd2;
  localparam logic [2:0] ST_HEAVY_R32  = 3'd3;
  localparam logic [2:0] ST_SHORT      = 3'd4;
  localparam logic [2:0] ST_DUP_GRID   = 3'd5;
  localparam logic [2:0] ST_BAD_COL    = 3'd6;

  localparam logic [2:0] COL_R32  = 3'd3;
  localparam logic [2:0] COL_GRID = 3'd4;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [2:0] CFG_LOADED  = 3'd0;
  localparam logic [2:0] CFG_PRESENT = 3'd1;
  localparam logic [2:0] CFG_CNT_G   = 3'd2;
  localparam logic [2:0] CFG_CNT_Q   = 3'd3;
  localparam logic [2:0] CFG_CNT_C   = 3'd4;
  localparam logic [2:0] CFG_CNT_B   = 3'd5;

  localparam logic [1:0] RD_FIRST = 2'd0;
  localparam logic [1:0] RD_LAST  = 2'd1;
  localparam logic [1:0] RD_MID   = 2'd2;
  localparam logic [1:0] RD_WIN   = 2'd3;

  localparam logic [1:0] MUL_HO_LO = 2'd0;
  localparam logic [1:0] MUL_HO_HI = 2'd1;
  localparam logic [1:0] MUL_HP_LO = 2'd2;
  localparam logic [1:0] MUL_HP_HI = 2'd3;

  localparam logic signed [47:0] ISAT   = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [48:0] ISAT_W = 49'sh0_7FFF_FFFF_FFFF;

  typedef struct packed {
    logic       capture;
    logic       pre_latch;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       lat_first;
    logic       lat_last;
    logic       bis_init;
    logic       bis_step;
    logic       win_init;
    logic       win_latch;
    logic       dup_latch;
    logic       nev_init;
    logic       div_start;
    logic       q_latch;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       acc_en;
    logic [1:0] acc_sel;
    logic       nev_store;
    logic       y_update;
    logic       finish;
  } btni_cmd_t;

  typedef struct packed {
    logic pre_done;
    logic bis_done;
    logic win_last;
    logic dup;
    logic div_done;
    logic row_last;
    logic nev_last;
  } btni_sts_t;

  function automatic logic signed [47:0] sat47(input logic signed [48:0] v);
    logic signed [47:0] r;
    if (v > ISAT_W) r = ISAT;
    else if (v < -ISAT_W) r = -ISAT;
    else r = v[47:0];
    return r;
  endfunction

endpackage

### hdl/btni_if.sv
interface btni_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [1:0]         flavor_class;
  logic [2:0]         column;
  logic [7:0]         row_index;
  logic [31:0]        energy;
  logic signed [31:0] load_value;

  modport source(output valid, req_type, flavor_class, column, row_index, energy,
                 load_value, input ready);
  modport sink(input valid, req_type, flavor_class, column, row_index, energy,
               load_value, output ready);
endinterface

interface btni_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [2:0]         status;

  modport source(output valid, result_value, status, input ready);
  modport sink(input valid, result_value, status, output ready);
endinterface

### hdl/btni_div.sv
module btni_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [62:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic [62:0] quot_o,
  output logic        done_o
);
  import btni_pkg::*;

  logic [31:0] rem_q, rem_d;
  logic [62:0] quot_q, quot_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;
  logic [32:0] trial_sub;

  assign trial     = {rem_q, quot_q[62]};
  assign trial_sub = trial - {1'b0, divisor_i};

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quot_d = dividend_i;
      cnt_d  = 6'd62;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, divisor_i}) begin
        rem_d  = trial_sub[31:0];
        quot_d = {quot_q[61:0], 1'b1};
      end else begin
        rem_d  = trial[31:0];
        quot_d = {quot_q[61:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign quot_o = quot_q;
  assign done_o = done_q;
endmodule

### hdl/btni_dp.sv
module btni_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  btni_pkg::btni_cmd_t  cmd_i,
  output btni_pkg::btni_sts_t  sts_o,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [8:0]           cfg_wdata_i,
  input  logic                 req_type_i,
  input  logic [1:0]           flavor_class_i,
  input  logic [2:0]           column_i,
  input  logic [7:0]           row_index_i,
  input  logic [31:0]          energy_i,
  input  logic signed [31:0]   load_value_i,
  output logic signed [31:0]   result_value_o,
  output logic [2:0]           status_o
);
  import btni_pkg::*;

  // configuration
  logic       loaded_q;
  logic [3:0] present_q;
  logic [8:0] cnt_q [NUM_CLASS];
  logic [8:0] cfg_cnt;

  // captured item
  logic        req_type_q;
  logic [1:0]  cls_q;
  logic [2:0]  col_q;
  logic [7:0]  row_q;
  logic [31:0] e_q;
  logic [31:0] lv_q;

  // tables
  logic [31:0] grid_mem [NUM_CLASS*DEPTH];
  logic [31:0] val_mem  [NUM_CLASS*4*DEPTH];
  logic [31:0] grid_rd_q, val_rd_q;
  logic [9:0]  grid_addr;
  logic [11:0] val_addr;
  logic        grid_we, val_we;

  // search and window
  logic [31:0]        g0_q, gl_q;
  logic signed [9:0]  jl_q, ju_q;
  logic [9:0]         jsum;
  logic [7:0]         jm;
  logic [7:0]         k_q;
  logic [1:0]         widx_q;
  logic [7:0]         win_row;
  logic [8:0]         n;
  logic               asc;
  logic signed [9:0]  jsel, kraw, kmax;

  // tableau
  logic [31:0]        xa_q [ORDER];
  logic signed [47:0] c_q  [ORDER];
  logic signed [47:0] d_q  [ORDER];
  logic [1:0]         s_q, m_q, i_q;
  logic signed [47:0] y_q;
  logic [46:0]        qmag_q;
  logic               qneg_q;
  logic [55:0]        prod_q;
  logic [79:0]        accc_q, accd_q;
  logic signed [31:0] res_value_q;
  logic [2:0]         res_status_q;

  logic [2:0]         pre_status;
  logic               pre_done;
  logic [1:0]         ip1, ipm;
  logic signed [48:0] w_diff;
  logic signed [47:0] w;
  logic [46:0]        w_mag;
  logic signed [32:0] den, ho, hp;
  logic [31:0]        den_mag, ho_mag, hp_mag;
  logic [62:0]        quot;
  logic               div_done;
  logic [31:0]        mul_a;
  logic [23:0]        mul_b;
  logic [63:0]        c_sh, d_sh;
  logic [47:0]        c_mag, d_mag;
  logic signed [47:0] c_new, d_new;
  logic [1:0]         s_best;
  logic [31:0]        dif_best, dif_i;
  logic               dup;
  logic signed [47:0] y_add;

  assign n = cnt_q[cls_q];

  assign cfg_cnt = (cfg_wdata_i > 9'(DEPTH)) ? 9'(DEPTH) : cfg_wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q  <= 1'b0;
      present_q <= '0;
      for (int c = 0; c < NUM_CLASS; c++) cnt_q[c] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LOADED:  loaded_q  <= cfg_wdata_i[0];
        CFG_PRESENT: present_q <= cfg_wdata_i[3:0];
        CFG_CNT_G:   cnt_q[0]  <= cfg_cnt;
        CFG_CNT_Q:   cnt_q[1]  <= cfg_cnt;
        CFG_CNT_C:   cnt_q[2]  <= cfg_cnt;
        CFG_CNT_B:   cnt_q[3]  <= cfg_cnt;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_type_q <= req_type_i;
      cls_q      <= flavor_class_i;
      col_q      <= column_i;
      row_q      <= row_index_i;
      e_q        <= energy_i;
      lv_q       <= load_value_i;
    end
  end

  // early status
  always_comb begin
    pre_status = ST_OK;
    pre_done   = 1'b1;
    if (req_type_q == REQ_LOAD) begin
      pre_status = (col_q > COL_GRID) ? ST_BAD_COL : ST_OK;
    end else if (!loaded_q) begin
      pre_status = ST_NOT_LOADED;
    end else if (col_q >= COL_GRID) begin
      pre_status = ST_BAD_COL;
    end else if (col_q == COL_R32 && cls_q[1]) begin
      pre_status = ST_HEAVY_R32;
    end else if (!present_q[cls_q]) begin
      pre_status = ST_ABSENT;
    end else if (n < 9'(ORDER)) begin
      pre_status = ST_SHORT;
    end else begin
      pre_done = 1'b0;
    end
  end

  // table access
  assign jsum    = 10'(jl_q + ju_q);
  assign jm      = jsum[8:1];
  assign win_row = k_q + 8'(widx_q);

  always_comb begin
    case (cmd_i.rd_sel)
      RD_FIRST: grid_addr = {cls_q, 8'd0};
      RD_LAST:  grid_addr = {cls_q, 8'(n - 9'd1)};
      RD_MID:   grid_addr = {cls_q, jm};
      RD_WIN:   grid_addr = {cls_q, win_row};
      default:  grid_addr = {cls_q, win_row};
    endcase
  end

  assign val_addr = cmd_i.pre_latch ? {cls_q, col_q[1:0], row_q} : {cls_q, col_q[1:0], win_row};
  assign grid_we  = cmd_i.pre_latch && req_type_q == REQ_LOAD && col_q == COL_GRID;
  assign val_we   = cmd_i.pre_latch && req_type_q == REQ_LOAD && col_q < COL_GRID;

  always_ff @(posedge clk_i) begin
    if (grid_we) grid_mem[{cls_q, row_q}] <= e_q;
    if (cmd_i.rd_en) grid_rd_q <= grid_mem[grid_addr];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) val_mem[val_addr] <= lv_q;
    if (cmd_i.rd_en) val_rd_q <= val_mem[val_addr];
  end

  // bisection
  assign asc = gl_q >= g0_q;

  always_comb begin
    if (e_q == g0_q) jsel = '0;
    else if (e_q == gl_q) jsel = 10'($signed({1'b0, n}) - 10'sd2);
    else jsel = jl_q;
    kraw = jsel - 10'sd1;
    kmax = 10'($signed({1'b0, n}) - 10'sd4);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_first) g0_q <= grid_rd_q;
    if (cmd_i.lat_last) gl_q <= grid_rd_q;
    if (cmd_i.bis_init) begin
      jl_q <= -10'sd1;
      ju_q <= $signed({1'b0, n});
    end else if (cmd_i.bis_step) begin
      if ((e_q >= grid_rd_q) == asc) jl_q <= $signed({2'b00, jm});
      else ju_q <= $signed({2'b00, jm});
    end
    if (cmd_i.win_init) begin
      widx_q <= '0;
      if (kraw < 10'sd0) k_q <= '0;
      else if (kraw > kmax) k_q <= kmax[7:0];
      else k_q <= kraw[7:0];
    end else if (cmd_i.win_latch) begin
      widx_q <= widx_q + 2'd1;
    end
  end

  // window checks
  always_comb begin
    dup = 1'b0;
    for (int a = 0; a < ORDER; a++)
      for (int b = a + 1; b < ORDER; b++)
        if (xa_q[a] == xa_q[b]) dup = 1'b1;
    s_best   = '0;
    dif_best = (e_q >= xa_q[0]) ? e_q - xa_q[0] : xa_q[0] - e_q;
    for (int a = 1; a < ORDER; a++) begin
      dif_i = (e_q >= xa_q[a]) ? e_q - xa_q[a] : xa_q[a] - e_q;
      if (dif_i < dif_best) begin
        s_best   = 2'(a);
        dif_best = dif_i;
      end
    end
  end

  // tableau step
  assign ip1     = i_q + 2'd1;
  assign ipm     = i_q + m_q;
  assign w_diff  = {c_q[ip1][47], c_q[ip1]} - {d_q[i_q][47], d_q[i_q]};
  assign w       = sat47(w_diff);
  assign w_mag   = w[47] ? 47'(-w) : w[46:0];
  assign den     = $signed({1'b0, xa_q[i_q]}) - $signed({1'b0, xa_q[ipm]});
  assign den_mag = den[32] ? 32'(-den) : den[31:0];
  assign ho      = $signed({1'b0, xa_q[i_q]}) - $signed({1'b0, e_q});
  assign hp      = $signed({1'b0, xa_q[ipm]}) - $signed({1'b0, e_q});
  assign ho_mag  = ho[32] ? 32'(-ho) : ho[31:0];
  assign hp_mag  = hp[32] ? 32'(-hp) : hp[31:0];

  btni_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({w_mag, 16'd0}),
    .divisor_i  (den_mag),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  assign mul_a = cmd_i.mul_sel[1] ? hp_mag : ho_mag;
  assign mul_b = cmd_i.mul_sel[0] ? {1'b0, qmag_q[46:24]} : qmag_q[23:0];

  assign c_sh  = accc_q[79:16];
  assign d_sh  = accd_q[79:16];
  assign c_mag = (c_sh > 64'(ISAT)) ? 48'(ISAT) : c_sh[47:0];
  assign d_mag = (d_sh > 64'(ISAT)) ? 48'(ISAT) : d_sh[47:0];
  assign c_new = (ho[32] ^ qneg_q) ? -$signed(c_mag) : $signed(c_mag);
  assign d_new = (hp[32] ^ qneg_q) ? -$signed(d_mag) : $signed(d_mag);

  assign y_add = ({1'b0, s_q, 1'b0} < (3'd4 - {1'b0, m_q})) ? c_q[s_q] : d_q[s_q - 2'd1];

  always_ff @(posedge clk_i) begin
    if (cmd_i.win_latch) begin
      xa_q[widx_q] <= grid_rd_q;
      c_q[widx_q]  <= 48'($signed(val_rd_q));
      d_q[widx_q]  <= 48'($signed(val_rd_q));
    end
    if (cmd_i.nev_init) begin
      s_q <= s_best;
      y_q <= c_q[s_best];
      m_q <= 2'd1;
      i_q <= '0;
    end
    if (cmd_i.q_latch) begin
      qmag_q <= (quot > 63'(ISAT)) ? ISAT[46:0] : quot[46:0];
      qneg_q <= w[47] ^ den[32];
    end
    if (cmd_i.mul_en) prod_q <= mul_a * mul_b;
    if (cmd_i.acc_en) begin
      case (cmd_i.acc_sel)
        MUL_HO_LO: accc_q <= 80'(prod_q);
        MUL_HO_HI: accc_q <= accc_q + {prod_q, 24'd0};
        MUL_HP_LO: accd_q <= 80'(prod_q);
        MUL_HP_HI: accd_q <= accd_q + {prod_q, 24'd0};
        default: ;
      endcase
    end
    if (cmd_i.nev_store) begin
      c_q[i_q] <= c_new;
      d_q[i_q] <= d_new;
      if (!sts_o.row_last) i_q <= ip1;
    end
    if (cmd_i.y_update) begin
      y_q <= sat47({y_q[47], y_q} + {y_add[47], y_add});
      if (!({1'b0, s_q, 1'b0} < (3'd4 - {1'b0, m_q}))) s_q <= s_q - 2'd1;
      m_q <= m_q + 2'd1;
      i_q <= '0;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.pre_latch) begin
      res_value_q  <= '0;
      res_status_q <= pre_status;
    end else if (cmd_i.dup_latch) begin
      res_value_q  <= '0;
      res_status_q <= ST_DUP_GRID;
    end else if (cmd_i.finish) begin
      res_status_q <= ST_OK;
      if (y_q > 48'sh7FFF_FFFF) res_value_q <= 32'sh7FFF_FFFF;
      else if (y_q < -48'sh8000_0000) res_value_q <= 32'sh8000_0000;
      else res_value_q <= y_q[31:0];
    end
  end

  assign result_value_o = res_value_q;
  assign status_o       = res_status_q;

  assign sts_o.pre_done = pre_done;
  assign sts_o.bis_done = (ju_q - jl_q) <= 10'sd1;
  assign sts_o.win_last = widx_q == 2'(ORDER - 1);
  assign sts_o.dup      = dup;
  assign sts_o.div_done = div_done;
  assign sts_o.row_last = i_q == (2'(ORDER - 1) - m_q);
  assign sts_o.nev_last = m_q == 2'(ORDER - 1);
endmodule

### hdl/btni_ctrl.sv
module btni_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output btni_pkg::btni_cmd_t cmd_o,
  input  btni_pkg::btni_sts_t sts_i
);
  import btni_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CHK  = 5'd1;
  localparam logic [4:0] S_RF   = 5'd2;
  localparam logic [4:0] S_RL   = 5'd3;
  localparam logic [4:0] S_BI   = 5'd4;
  localparam logic [4:0] S_BR   = 5'd5;
  localparam logic [4:0] S_BC   = 5'd6;
  localparam logic [4:0] S_WI   = 5'd7;
  localparam logic [4:0] S_WR   = 5'd8;
  localparam logic [4:0] S_WL   = 5'd9;
  localparam logic [4:0] S_DUP  = 5'd10;
  localparam logic [4:0] S_DS   = 5'd11;
  localparam logic [4:0] S_DW   = 5'd12;
  localparam logic [4:0] S_M0   = 5'd13;
  localparam logic [4:0] S_M1   = 5'd14;
  localparam logic [4:0] S_M2   = 5'd15;
  localparam logic [4:0] S_M3   = 5'd16;
  localparam logic [4:0] S_M4   = 5'd17;
  localparam logic [4:0] S_NS   = 5'd18;
  localparam logic [4:0] S_YU   = 5'd19;
  localparam logic [4:0] S_FIN  = 5'd20;
  localparam logic [4:0] S_OUT  = 5'd21;

  logic [4:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (sts_i.pre_done) begin
          cmd_o.pre_latch = 1'b1;
          state_d = S_OUT;
        end else begin
          state_d = S_RF;
        end
      end
      S_RF: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_FIRST;
        state_d = S_RL;
      end
      S_RL: begin
        cmd_o.lat_first = 1'b1;
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_sel    = RD_LAST;
        state_d = S_BI;
      end
      S_BI: begin
        cmd_o.lat_last = 1'b1;
        cmd_o.bis_init = 1'b1;
        state_d = S_BR;
      end
      S_BR: begin
        if (sts_i.bis_done) begin
          state_d = S_WI;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_MID;
          state_d = S_BC;
        end
      end
      S_BC: begin
        cmd_o.bis_step = 1'b1;
        state_d = S_BR;
      end
      S_WI: begin
        cmd_o.win_init = 1'b1;
        state_d = S_WR;
      end
      S_WR: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_WIN;
        state_d = S_WL;
      end
      S_WL: begin
        cmd_o.win_latch = 1'b1;
        state_d = sts_i.win_last ? S_DUP : S_WR;
      end
      S_DUP: begin
        if (sts_i.dup) begin
          cmd_o.dup_latch = 1'b1;
          state_d = S_OUT;
        end else begin
          cmd_o.nev_init = 1'b1;
          state_d = S_DS;
        end
      end
      S_DS: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DW;
      end
      S_DW: begin
        if (sts_i.div_done) begin
          cmd_o.q_latch = 1'b1;
          state_d = S_M0;
        end
      end
      S_M0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_HO_LO;
        state_d = S_M1;
      end
      S_M1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_HO_HI;
        cmd_o.acc_en  = 1'b1;
        cmd_o.acc_sel = MUL_HO_LO;
        state_d = S_M2;
      end
      S_M2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_HP_LO;
        cmd_o.acc_en  = 1'b1;
        cmd_o.acc_sel = MUL_HO_HI;
        state_d = S_M3;
      end
      S_M3: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_HP_HI;
        cmd_o.acc_en  = 1'b1;
        cmd_o.acc_sel = MUL_HP_LO;
        state_d = S_M4;
      end
      S_M4: begin
        cmd_o.acc_en  = 1'b1;
        cmd_o.acc_sel = MUL_HP_HI;
        state_d = S_NS;
      end
      S_NS: begin
        cmd_o.nev_store = 1'b1;
        state_d = sts_i.row_last ? S_YU : S_DS;
      end
      S_YU: begin
        cmd_o.y_update = 1'b1;
        state_d = sts_i.nev_last ? S_FIN : S_DS;
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

### hdl/bisect_table_neville_interp.sv
// Energy table lookup with four-point Neville interpolation.
// Input channel (in_if): one item is either a load, which writes one grid or
// value entry of a flavor class, or a query, which returns the interpolated
// value of one column at the given energy. Output channel (out_if): exactly
// one item per input item, value plus status; value is zero for loads and
// for every error status.
// Configuration: write cfg_we_i with cfg_idx_i (0 loaded flag, 1 presence
// mask, 2..5 per-class grid counts, counts above 256 clamp to 256) only while
// the block is idle.
// A load or an early error goes from the check state straight to the output
// state. A full query runs the check, the first and last grid reads, two to
// nine bisection probes, the four window reads, the duplicate check, six
// tableau steps (each waiting on the 63-step bit-serial divider), three
// running-sum updates and the final saturation.
// One item is in flight at a time: in_if.ready is high only while idle, so a
// new item is taken only after the result has been taken. The result waits in its
// output register while out_if.ready is low; no new item enters until then.
// Reset clears the configuration and control state; the table memories are
// not cleared and must be loaded before use.
module bisect_table_neville_interp (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_we_i,
  input logic [2:0] cfg_idx_i,
  input logic [8:0] cfg_wdata_i,
  btni_req_if.sink  in_if,
  btni_rsp_if.source out_if
);
  import btni_pkg::*;

  btni_cmd_t cmd;
  btni_sts_t sts;

  // sequencer: owns the handshakes and steps the datapath
  btni_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // tables, search registers, tableau and result register
  btni_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req_type_i     (in_if.req_type),
    .flavor_class_i (in_if.flavor_class),
    .column_i       (in_if.column),
    .row_index_i    (in_if.row_index),
    .energy_i       (in_if.energy),
    .load_value_i   (in_if.load_value),
    .result_value_o (out_if.result_value),
    .status_o       (out_if.status)
  );
endmodule

### hdl/btni_checker.sv
module btni_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic signed [31:0] result_value_i,
  input logic [2:0]        status_i
);
  import btni_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_OK |-> result_value_i == '0)
    else $error("nonzero value with error status");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i <= ST_BAD_COL)
    else $error("status code out of range");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("accepted a second item while busy");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input open while a result waits");
endmodule

bind bisect_table_neville_interp btni_checker u_btni_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_if.valid),
  .in_ready_i     (in_if.ready),
  .out_valid_i    (out_if.valid),
  .out_ready_i    (out_if.ready),
  .result_value_i (out_if.result_value),
  .status_i       (out_if.status)
);

### dv/bisect_table_neville_interp_tb.sv
`timescale 1ns / 100ps
module bisect_table_neville_interp_tb;
  import btni_pkg::*;

  // Tableau entries saturate symmetrically at this magnitude.
  localparam longint CLIP47 = 64'sh7FFF_FFFF_FFFF;
  localparam longint LIMIT_CYCLES = 3_000_000;

  typedef struct {
    logic [2:0]         status;
    logic signed [31:0] value;
  } answer_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_idx = '0;
  logic [8:0] cfg_wdata = '0;

  btni_req_if req_if ();
  btni_rsp_if rsp_if ();

  bisect_table_neville_interp dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (req_if),
    .out_if      (rsp_if)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the tables, the registers and what has been written so far.
  logic [31:0] grid_mem [4][256];
  logic [31:0] val_mem  [4][4][256];
  bit          grid_wr  [4][256];
  bit          val_wr   [4][4][256];
  bit          loaded_m;
  logic [3:0]  present_m;
  int          count_m  [4];

  answer_t awaited_answers[$];
  int      errors = 0;
  longint  cycles = 0;
  int      burst_left = 0;
  int      stall_pct = 20;
  int      hold_req = 0;
  int      hold_left = 0;

  function automatic longint clip47(input longint v);
    if (v > CLIP47) return CLIP47;
    if (v < -CLIP47) return -CLIP47;
    return v;
  endfunction

  function automatic longint unsigned absv(input longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  // trunc(a*b/2^16), saturated
  function automatic longint mulq16(input longint a, input longint b);
    longint unsigned ua, ub, p;
    bit neg;
    ua = absv(a);
    ub = absv(b);
    neg = (a < 0) != (b < 0);
    if (ua != 0 && ub > 64'h7FFF_FFFF_FFFF_FFFF / ua) return neg ? -CLIP47 : CLIP47;
    p = (ua * ub) / 65536;
    if (p > CLIP47) p = CLIP47;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  // Check the error cases, bisect the class grid, clamp the window and run the Neville tableau.
  function automatic logic [2:0] lookup_interp(input logic [1:0] cls, input logic [2:0] col,
                                               input logic [31:0] e,
                                               output logic signed [31:0] v);
    int n, jl, ju, jm, j, k, s;
    bit asc;
    longint xa[4], c[4], d[4], x, y, w, q, ho, hp;
    longint unsigned dif, dt;
    v = '0;
    if (!loaded_m) return ST_NOT_LOADED;
    if (col >= 4) return ST_BAD_COL;
    if (col == COL_R32 && cls >= 2) return ST_HEAVY_R32;
    if (!present_m[cls]) return ST_ABSENT;
    n = count_m[cls];
    if (n < ORDER) return ST_SHORT;
    asc = grid_mem[cls][n-1] >= grid_mem[cls][0];
    jl = -1;
    ju = n;
    while (ju - jl > 1) begin
      jm = (ju + jl) / 2;
      if ((e >= grid_mem[cls][jm]) == asc) jl = jm;
      else ju = jm;
    end
    if (e == grid_mem[cls][0]) j = 0;
    else if (e == grid_mem[cls][n-1]) j = n - 2;
    else j = jl;
    k = j - 1;
    if (k < 0) k = 0;
    if (k > n - ORDER) k = n - ORDER;
    for (int i = 0; i < 4; i++) begin
      xa[i] = grid_mem[cls][k+i];
      c[i] = $signed(val_mem[cls][col][k+i]);
      d[i] = c[i];
    end
    for (int i = 0; i < 4; i++)
      for (int m = i + 1; m < 4; m++)
        if (xa[i] == xa[m]) return ST_DUP_GRID;
    x = e;
    s = 0;
    dif = absv(x - xa[0]);
    for (int i = 1; i < 4; i++) begin
      dt = absv(x - xa[i]);
      if (dt < dif) begin
        s = i;
        dif = dt;
      end
    end
    y = c[s];
    for (int m = 1; m < 4; m++) begin
      for (int i = 0; i < 4 - m; i++) begin
        ho = xa[i] - x;
        hp = xa[i+m] - x;
        w = clip47(c[i+1] - d[i]);
        q = clip47((w * 65536) / (xa[i] - xa[i+m]));
        d[i] = mulq16(hp, q);
        c[i] = mulq16(ho, q);
      end
      if (2 * s < 4 - m) begin
        y = clip47(y + c[s]);
      end else begin
        s--;
        if (s >= 0) y = clip47(y + d[s]);
      end
    end
    if (y > 64'sd2147483647) y = 64'sd2147483647;
    if (y < -64'sd2147483648) y = -64'sd2147483648;
    v = y[31:0];
    return ST_OK;
  endfunction

  // A query that would read a never-written entry must not be issued.
  function automatic bit reads_written(input logic [1:0] cls, input logic [2:0] col);
    if (!loaded_m || col >= 4 || (col == COL_R32 && cls >= 2) || !present_m[cls] ||
        count_m[cls] < ORDER) return 1'b1;
    for (int r = 0; r < count_m[cls]; r++)
      if (!grid_wr[cls][r] || !val_wr[cls][col][r]) return 1'b0;
    return 1'b1;
  endfunction

  // Sample outputs at the rising edge; stop a hung run.
  always @(posedge clk_i) begin
    answer_t a;
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end else if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (awaited_answers.size() == 0) begin
        $display("%0t: unexpected result value=%h status=%0d", $time,
                 rsp_if.result_value, rsp_if.status);
        errors++;
      end else begin
        a = awaited_answers.pop_front();
        if (rsp_if.status !== a.status) begin
          $display("%0t: status expected %0d actual %0d", $time, a.status, rsp_if.status);
          errors++;
        end
        if (rsp_if.result_value !== a.value) begin
          $display("%0t: value expected %h actual %h", $time, a.value, rsp_if.result_value);
          errors++;
        end
      end
    end
  end

  // Receiver: random stalls, plus long hold-offs on request.
  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready = 1'b0;
    end else begin
      rsp_if.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic drain();
    while (awaited_answers.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [2:0] idx, input int val);
    drain();
    @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = val[8:0];
    @(negedge clk_i);
    cfg_we = 1'b0;
    case (idx)
      CFG_LOADED:  loaded_m = val[0];
      CFG_PRESENT: present_m = val[3:0];
      default:     count_m[idx - CFG_CNT_G] = (val[8:0] > 256) ? 256 : val[8:0];
    endcase
  endtask

  // Offer one item in a burst pattern, hold until taken, predict its answer.
  task automatic send_item(input logic rq, input logic [1:0] cls, input logic [2:0] col,
                           input logic [7:0] row, input logic [31:0] en,
                           input logic [31:0] lv);
    answer_t a;
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = $urandom_range(3) == 0 ? 0 : $urandom_range(1, 12);
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    req_if.req_type = rq;
    req_if.flavor_class = cls;
    req_if.column = col;
    req_if.row_index = row;
    req_if.energy = en;
    req_if.load_value = lv;
    req_if.valid = 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    a.value = '0;
    if (rq == REQ_LOAD) begin
      a.status = (col > COL_GRID) ? ST_BAD_COL : ST_OK;
      if (col == COL_GRID) begin
        grid_mem[cls][row] = en;
        grid_wr[cls][row] = 1'b1;
      end else if (col < COL_GRID) begin
        val_mem[cls][col][row] = lv;
        val_wr[cls][col][row] = 1'b1;
      end
    end else begin
      a.status = lookup_interp(cls, col, en, a.value);
    end
    awaited_answers.insert(awaited_answers.size(), a);
    @(negedge clk_i);
    req_if.valid = 1'b0;
  endtask

  function automatic logic [31:0] rand_value();
    if ($urandom_range(3) == 0) return $urandom;
    return $urandom_range(0, 2097152) - 1048576;
  endfunction

  // Load a grid (ascending, descending, or with one duplicate) and its value columns (all four, or column 0 only).
  task automatic fill_class(input logic [1:0] cls, input int n, input int shape,
                            input bit all_cols);
    logic [31:0] g[256];
    logic [31:0] scale, base;
    int r2;
    scale = 32'd1 << $urandom_range(0, 20);
    base = $urandom_range(0, 32'hFFFF_FFFF - n * scale);
    for (int r = 0; r < n; r++) begin
      base = base + $urandom_range(1, scale);
      g[r] = base;
    end
    if (shape == 2 && n > 1) begin
      r2 = $urandom_range(1, n - 1);
      g[r2] = g[r2-1];
    end
    for (int r = 0; r < n; r++) begin
      r2 = (shape == 1) ? n - 1 - r : r;
      send_item(REQ_LOAD, cls, COL_GRID, 8'(r), g[r2], $urandom);
      for (int c = 0; c < 4; c++)
        if (all_cols || c == 0) send_item(REQ_LOAD, cls, 3'(c), 8'(r), $urandom, rand_value());
    end
  endtask

  // Query energy: exact grid point, an endpoint, inside the range, or anywhere.
  function automatic logic [31:0] pick_energy(input logic [1:0] cls);
    int n;
    logic [31:0] lo, hi;
    n = count_m[cls];
    if (n < ORDER || !grid_wr[cls][0] || !grid_wr[cls][n-1]) return $urandom;
    lo = grid_mem[cls][0];
    hi = grid_mem[cls][n-1];
    if (lo > hi) begin
      lo = grid_mem[cls][n-1];
      hi = grid_mem[cls][0];
    end
    case ($urandom_range(4))
      0: return grid_wr[cls][0] ? grid_mem[cls][$urandom_range(n - 1)] : lo;
      1: return $urandom;
      2: return $urandom_range(0, 1) ? lo : hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  // Before any configuration every query reports not-loaded; unknown load
  // columns are rejected.
  task automatic test_unloaded();
    send_item(REQ_QUERY, 0, 0, 0, $urandom, 0);
    send_item(REQ_QUERY, 3, 7, 0, 32'hFFFF_FFFF, 0);
    send_item(REQ_LOAD, 1, 5, 8'hFF, 0, 32'h8000_0000);
    send_item(REQ_LOAD, 2, 7, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
  endtask

  // Walk down the status priority one case at a time.
  task automatic test_error_order();
    set_reg(CFG_LOADED, 1);
    set_reg(CFG_PRESENT, 0);
    for (int c = 0; c < 4; c++) set_reg(3'(CFG_CNT_G + c), 0);
    send_item(REQ_QUERY, 2, 3'd6, 0, 0, 0);     // bad column beats heavy R32
    send_item(REQ_QUERY, 2, COL_R32, 0, 0, 0);  // heavy R32 with class absent
    send_item(REQ_QUERY, 3, COL_R32, 0, 0, 0);
    send_item(REQ_QUERY, 0, 0, 0, 0, 0);        // absent
    set_reg(CFG_PRESENT, 15);
    send_item(REQ_QUERY, 1, 1, 0, 0, 0);        // empty table is too short
    set_reg(CFG_CNT_Q, 3);
    send_item(REQ_QUERY, 1, 2, 0, 0, 0);
  endtask

  // Endpoints, out-of-range energies, descending grid, smallest table,
  // duplicate grid points.
  task automatic test_interp_edges();
    set_reg(CFG_CNT_G, 8);
    set_reg(CFG_CNT_Q, 6);
    set_reg(CFG_CNT_C, 4);
    set_reg(CFG_CNT_B, 5);
    fill_class(0, 8, 0, 1);
    fill_class(1, 6, 1, 1);
    fill_class(2, 4, 0, 1);
    fill_class(3, 5, 2, 1);
    send_item(REQ_QUERY, 0, 0, 0, grid_mem[0][0], 0);
    send_item(REQ_QUERY, 0, 1, 0, grid_mem[0][7], 0);
    send_item(REQ_QUERY, 0, 2, 0, 32'd0, 0);
    send_item(REQ_QUERY, 0, COL_R32, 0, 32'hFFFF_FFFF, 0);
    send_item(REQ_QUERY, 0, 0, 0, grid_mem[0][3] + 1, 0);
    send_item(REQ_QUERY, 1, 0, 0, grid_mem[1][0], 0);
    send_item(REQ_QUERY, 1, COL_R32, 0, grid_mem[1][5], 0);
    send_item(REQ_QUERY, 1, 1, 0, grid_mem[1][2] - 1, 0);
    send_item(REQ_QUERY, 2, 2, 0, grid_mem[2][1], 0);
    send_item(REQ_QUERY, 3, 0, 0, grid_mem[3][2], 0);
    send_item(REQ_QUERY, 3, COL_R32, 0, 0, 0);
  endtask

  // Hold the receiver off while queries keep coming, then pause the sender
  // until everything is back.
  task automatic test_backpressure();
    hold_req = 900;
    for (int i = 0; i < 4; i++)
      send_item(REQ_QUERY, 0, 3'($urandom_range(3)), 0, pick_energy(0), 0);
    drain();
    for (int i = 0; i < 3; i++) send_item(REQ_QUERY, 1, 0, 0, pick_energy(1), 0);
  endtask

  // Two register settings, each with fresh tables and a random mix.
  task automatic test_random_phases();
    logic [1:0] cls;
    logic [2:0] col;
    int pct[2] = '{30, 70};
    for (int ph = 0; ph < 2; ph++) begin
      stall_pct = pct[ph];
      set_reg(CFG_PRESENT, ph == 0 ? 15 : $urandom_range(15));
      for (int c = 0; c < 4; c++) begin
        set_reg(3'(CFG_CNT_G + c), (c == ph) ? 4 : $urandom_range(4, 6));
        fill_class(2'(c), count_m[c], ($urandom_range(5) == 0) ? 2 : $urandom_range(1), 1);
      end
      for (int i = 0; i < 40; i++) begin
        cls = 2'($urandom_range(3));
        if ($urandom_range(4) == 0) begin
          send_item(REQ_LOAD, cls, 3'($urandom_range(7)), 8'($urandom), $urandom, $urandom);
        end else begin
          col = ($urandom_range(9) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(3));
          if (reads_written(cls, col))
            send_item(REQ_QUERY, cls, col, 8'($urandom), pick_energy(cls), 0);
        end
      end
    end
    stall_pct = 20;
  endtask

  // A count beyond the depth clamps to a full 256-row table; then a cleared loaded flag gives not-loaded.
  task automatic test_full_depth();
    set_reg(CFG_PRESENT, 1);
    set_reg(CFG_CNT_G, 511);
    fill_class(0, 256, $urandom_range(1), 0);
    for (int i = 0; i < 30; i++)
      send_item(REQ_QUERY, 0, 0, 8'($urandom), pick_energy(0), $urandom);
    set_reg(CFG_LOADED, 0);
    send_item(REQ_QUERY, 0, 0, 0, pick_energy(0), 0);
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.req_type = 1'b0;
    req_if.flavor_class = '0;
    req_if.column = '0;
    req_if.row_index = '0;
    req_if.energy = '0;
    req_if.load_value = '0;
    rsp_if.ready = 1'b0;
    loaded_m = 1'b0;
    present_m = '0;
    for (int c = 0; c < 4; c++) begin
      count_m[c] = 0;
      for (int r = 0; r < 256; r++) begin
        grid_mem[c][r] = '0;
        grid_wr[c][r] = 1'b0;
        for (int k = 0; k < 4; k++) begin
          val_mem[c][k][r] = '0;
          val_wr[c][k][r] = 1'b0;
        end
      end
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_unloaded();
    test_error_order();
    test_interp_edges();
    test_backpressure();
    test_random_phases();
    test_full_depth();

    // Let the last answers drain before reporting.
    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/btni_pkg.sv
hdl/btni_if.sv
hdl/btni_div.sv
hdl/btni_dp.sv
hdl/btni_ctrl.sv
hdl/bisect_table_neville_interp.sv
hdl/btni_checker.sv
dv/bisect_table_neville_interp_tb.sv
